>>> design/accpg_pkg.sv
// Shared types, constants and helpers for the access code correlator packet gate.
`default_nettype none

package accpg_pkg;

  localparam int HIST_W  = 64;               // bit history length
  localparam int GROUP_W = 8;                // history bits per partial count
  localparam int GROUPS  = HIST_W / GROUP_W; // partial counts per word
  localparam int CNT_W   = $clog2(GROUP_W + 1);
  localparam int DIST_W  = $clog2(HIST_W + 1);
  localparam int LEN_W   = 7;                // code_length and max_wrong_bits
  localparam int PKT_W   = 16;               // packet_bits and bits left
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 5;
  localparam int IDX_LSB = 3;                // registers on 8-byte spacing

  typedef enum logic [1:0] {
    REG_CODE   = 2'd0,
    REG_LEN    = 2'd1,
    REG_THRESH = 2'd2,
    REG_PKT    = 2'd3
  } reg_idx_t;

  typedef logic [GROUPS-1:0][CNT_W-1:0] group_cnt_t;

  // Stage 1 word handed from the front end to the packet gate
  typedef struct packed {
    logic       valid;
    logic       rx;
    group_cnt_t cnt;
  } s1_t;

  function automatic logic [CNT_W-1:0] popcount8(input logic [GROUP_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/access_code_correlator_packet_gate.sv
// Top level: access code correlator with Hamming threshold and packet gate.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | to block  | in_valid / in_stall      | rx_bit
//  out     | from block| out_valid / out_stall    | out_bit, first_of_packet, last_of_packet
//  cfg     | to block  | APB psel/penable/pwrite  | paddr (8-byte spacing), pwdata, prdata
//
// One word is taken per cycle while in_stall is low; an accepted word is registered
// in stage 1 (history shift, mask, byte counts) and then, when stage 1 moves on,
// in the output register (stage 2: count sum, threshold compare, packet counter).
// Reset (rst, synchronous) clears the history, the packet counter, the pipeline
// valids and loads register defaults. A stalled output holds stage 1; the input
// stalls only when stage 1 is full and cannot move on.
`default_nettype none

module access_code_correlator_packet_gate (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          rx_bit,
  // output channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_bit,
  output      logic                          first_of_packet,
  output      logic                          last_of_packet,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [accpg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [accpg_pkg::APB_DW-1:0]  pwdata,
  output      logic [accpg_pkg::APB_DW-1:0]  prdata,
  output      logic                          pready
);

  // configuration registers
  logic [accpg_pkg::HIST_W-1:0] access_code_word;
  logic [accpg_pkg::LEN_W-1:0]  code_length;
  logic [accpg_pkg::LEN_W-1:0]  max_wrong_bits;
  logic [accpg_pkg::PKT_W-1:0]  packet_bits;

  accpg_pkg::reg_idx_t          reg_idx;
  logic                         cfg_wr;

  // pipeline
  accpg_pkg::s1_t               s1;
  logic                         advance;
  logic                         in_acc;

  // packet gate
  logic [accpg_pkg::PKT_W-1:0]  bits_left;
  logic [accpg_pkg::PKT_W-1:0]  bits_left_next;
  logic [accpg_pkg::PKT_W-1:0]  pkt_len;
  logic [accpg_pkg::DIST_W-1:0] ham_dist;
  logic                         emit;
  logic                         first_next;
  logic                         last_next;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = accpg_pkg::reg_idx_t'(paddr[accpg_pkg::APB_AW-1:accpg_pkg::IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      access_code_word <= '0;
      code_length      <= accpg_pkg::LEN_W'(accpg_pkg::HIST_W);
      max_wrong_bits   <= '0;
      packet_bits      <= accpg_pkg::PKT_W'(8);
    end else if (cfg_wr) begin
      case (reg_idx)
        accpg_pkg::REG_CODE:   access_code_word <= pwdata;
        accpg_pkg::REG_LEN:    code_length      <= pwdata[accpg_pkg::LEN_W-1:0];
        accpg_pkg::REG_THRESH: max_wrong_bits   <= pwdata[accpg_pkg::LEN_W-1:0];
        accpg_pkg::REG_PKT:    packet_bits      <= pwdata[accpg_pkg::PKT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      accpg_pkg::REG_CODE:   prdata = access_code_word;
      accpg_pkg::REG_LEN:    prdata = accpg_pkg::APB_DW'(code_length);
      accpg_pkg::REG_THRESH: prdata = accpg_pkg::APB_DW'(max_wrong_bits);
      accpg_pkg::REG_PKT:    prdata = accpg_pkg::APB_DW'(packet_bits);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // stage 1 moves on whenever the output register is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1.valid && !advance;
  assign in_acc   = in_valid && !in_stall;

  accpg_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_acc),
    .advance          (advance),
    .rx_bit           (rx_bit),
    .access_code_word (access_code_word),
    .code_length      (code_length),
    .s1               (s1)
  );

  // ---------------------------------------------------------------- stage 2
  // Hamming distance from the eight byte counts
  always_comb begin
    ham_dist = '0;
    for (int g = 0; g < accpg_pkg::GROUPS; g++) begin
      ham_dist = ham_dist + accpg_pkg::DIST_W'(s1.cnt[g]);
    end
  end

  // packet length of zero behaves as one
  assign pkt_len = (packet_bits == '0) ? accpg_pkg::PKT_W'(1) : packet_bits;

  // Open packet: pass the bit, no compare. Otherwise a match opens a packet.
  always_comb begin
    emit           = 1'b0;
    first_next     = 1'b0;
    last_next      = 1'b0;
    bits_left_next = bits_left;
    if (bits_left != '0) begin
      emit           = 1'b1;
      last_next      = (bits_left == accpg_pkg::PKT_W'(1));
      bits_left_next = bits_left - accpg_pkg::PKT_W'(1);
    end else if (accpg_pkg::LEN_W'(ham_dist) <= max_wrong_bits) begin
      emit           = 1'b1;
      first_next     = 1'b1;
      last_next      = (pkt_len == accpg_pkg::PKT_W'(1));
      bits_left_next = pkt_len - accpg_pkg::PKT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1.valid && emit;
      if (s1.valid) begin
        bits_left <= bits_left_next;
      end
    end
  end

  // result payload, loaded only with a real result
  always_ff @(posedge clk) begin
    if (advance && s1.valid && emit) begin
      out_bit         <= s1.rx;
      first_of_packet <= first_next;
      last_of_packet  <= last_next;
    end
  end

`ifndef NO_ASSERTIONS
  // the last word of a packet closes it
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_packet |-> bits_left == '0)
    else $error("packet still open after last word");

  // a first word that is not also last leaves a packet open
  a_first_opens: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_of_packet && !last_of_packet |-> bits_left != '0)
    else $error("packet not opened after first word");

  // every word moved on inside an open packet is delivered
  a_open_emits: assert property (@(posedge clk) disable iff (rst)
    s1.valid && advance && bits_left != '0 |=> out_valid && !first_of_packet)
    else $error("packet word dropped");
`endif

endmodule

`default_nettype wire

>>> design/accpg_front.sv
// Bit history, compare mask and per-byte mismatch counts (stage 1 register).
`default_nettype none

module accpg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          advance,
  input  wire logic                          rx_bit,
  input  wire logic [accpg_pkg::HIST_W-1:0]  access_code_word,
  input  wire logic [accpg_pkg::LEN_W-1:0]   code_length,
  output accpg_pkg::s1_t                     s1
);

  logic [accpg_pkg::HIST_W-1:0] history;
  logic [accpg_pkg::HIST_W-1:0] history_next;
  logic [accpg_pkg::HIST_W-1:0] mask;
  logic [accpg_pkg::HIST_W-1:0] diff;
  accpg_pkg::group_cnt_t        cnt_next;

  assign history_next = {history[accpg_pkg::HIST_W-2:0], rx_bit};

  // lengths of 64 and above compare every bit
  always_comb begin
    for (int i = 0; i < accpg_pkg::HIST_W; i++) begin
      mask[i] = (accpg_pkg::LEN_W'(i) < code_length);
    end
  end

  assign diff = (history_next ^ access_code_word) & mask;

  always_comb begin
    for (int g = 0; g < accpg_pkg::GROUPS; g++) begin
      cnt_next[g] = accpg_pkg::popcount8(diff[g*accpg_pkg::GROUP_W +: accpg_pkg::GROUP_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= '0;
      s1.valid <= 1'b0;
    end else begin
      if (accept) begin
        history  <= history_next;
        s1.valid <= 1'b1;
        s1.rx    <= rx_bit;
        s1.cnt   <= cnt_next;
      end else if (advance) begin
        s1.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_access_code_correlator_packet_gate.sv
// Self-checking testbench for the access code correlator packet gate.
`timescale 1ns / 1ps

module tb_access_code_correlator_packet_gate;

  // One output word as the gate should present it
  typedef struct packed {
    logic data;
    logic first;
    logic last;
  } gate_bit_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         rx_bit = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_bit;
  logic                         first_of_packet;
  logic                         last_of_packet;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [accpg_pkg::APB_AW-1:0] paddr = '0;
  logic [accpg_pkg::APB_DW-1:0] pwdata = '0;
  logic [accpg_pkg::APB_DW-1:0] prdata;
  logic                         pready;

  access_code_correlator_packet_gate DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_bit          (rx_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bit         (out_bit),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the gate: history, open packet count and the four registers,
  // all starting from their reset values.
  logic [63:0] sh_history = '0;
  logic [15:0] sh_left    = '0;
  logic [63:0] cfg_code   = '0;
  logic [6:0]  cfg_len    = 7'd64;
  logic [6:0]  cfg_thresh = 7'd0;
  logic [15:0] cfg_pkt    = 16'd8;

  gate_bit_t   gate_q[$];   // output words still owed by the gate
  gate_bit_t   exp_w;

  int err_count     = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int packets_seen  = 0;
  int settings_seen = 0;

  // Sender burst control and receiver stall pattern
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  bit          out_quiet  = 1'b0;
  logic [15:0] stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (long packet under heavy stall)
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Works out what one accepted bit should produce. Bits inside an open
  // packet skip the comparison; otherwise the masked Hamming distance against
  // the code decides whether a new packet opens.
  function automatic void gate_predict(input logic b);
    logic [63:0] mask;
    int          n_wrong;
    logic [15:0] plen;
    sh_history = {sh_history[62:0], b};
    if (sh_left != 16'd0) begin
      gate_q.push_back('{b, 1'b0, sh_left == 16'd1});
      sh_left--;
      return;
    end
    // length zero compares nothing, 64 and anything past it compares the lot
    if (cfg_len == 7'd0) mask = '0;
    else if (cfg_len >= 7'd64) mask = '1;
    else mask = ~64'd0 >> (64 - cfg_len);
    n_wrong = $countones((sh_history ^ cfg_code) & mask);
    if (n_wrong > cfg_thresh) return;
    // a zero packet length still gives the matching bit alone
    plen = (cfg_pkt == 16'd0) ? 16'd1 : cfg_pkt;
    gate_q.push_back('{b, 1'b1, plen == 16'd1});
    sh_left = plen - 16'd1;
    packets_seen++;
  endfunction

  // Output check first, then prediction: a word taken at this edge cannot
  // leave the gate at the same edge, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (gate_q.size() == 0) begin
          $error("output word with nothing expected (bit %0b first %0b last %0b)",
                 out_bit, first_of_packet, last_of_packet);
          err_count++;
        end else begin
          exp_w = gate_q.pop_front();
          if (out_bit !== exp_w.data) begin
            $error("out_bit: expected %0b, got %0b", exp_w.data, out_bit);
            err_count++;
          end
          if (first_of_packet !== exp_w.first) begin
            $error("first_of_packet: expected %0b, got %0b", exp_w.first, first_of_packet);
            err_count++;
          end
          if (last_of_packet !== exp_w.last) begin
            $error("last_of_packet: expected %0b, got %0b", exp_w.last, last_of_packet);
            err_count++;
          end
          words_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        gate_predict(rx_bit);
        words_sent++;
      end
    end
  end

  // Receiver: switches at random between no stall, light random, heavy random
  // and a fixed 1-in-4 pattern whenever stall_tick[7:0] wraps. Held quiet while flushing.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    if (out_quiet) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[2] & stall_tick[1];
      endcase
    end
  end

  // Sends one bit, opening a new burst (after an optional gap) when the
  // current one is used up. Returns at the edge that took the word.
  task automatic drive_bit(input logic b);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_bit   <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_noise(input int n);
    repeat (n) drive_bit(1'($urandom_range(0, 1)));
  endtask

  // Sends the low len bits of the code, oldest first, with some bits flipped
  task automatic send_code(input logic [63:0] code, input int len, input int flips);
    logic [63:0] pat;
    int          n;
    n   = (len > 64) ? 64 : len;
    pat = code;
    repeat (flips) if (n > 0) pat[$urandom_range(0, n - 1)] ^= 1'b1;
    for (int i = n - 1; i >= 0; i--) drive_bit(pat[i]);
  endtask

  // Waits for every owed word, then flushes the pipe with the receiver
  // ready so that bits with no output cannot be left inside.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gate_q.size() != 0) @(posedge clk);
    out_quiet = 1'b1;
    repeat (6) @(posedge clk);
    out_quiet = 1'b0;
  endtask

  task automatic write_reg(input accpg_pkg::reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= accpg_pkg::APB_AW'(idx) << accpg_pkg::IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      accpg_pkg::REG_CODE:   cfg_code   = value;
      accpg_pkg::REG_LEN:    cfg_len    = value[6:0];
      accpg_pkg::REG_THRESH: cfg_thresh = value[6:0];
      accpg_pkg::REG_PKT:    cfg_pkt    = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] code, input logic [6:0] len,
                            input logic [6:0] thr, input logic [15:0] pkt);
    write_reg(accpg_pkg::REG_CODE, code);
    write_reg(accpg_pkg::REG_LEN, {57'd0, len});
    write_reg(accpg_pkg::REG_THRESH, {57'd0, thr});
    write_reg(accpg_pkg::REG_PKT, {48'd0, pkt});
    settings_seen++;
  endtask

  // Reset values: zero code over 64 bits, so the all-zero history matches
  // on the very first 0 and an 8-bit packet follows.
  task automatic test_reset_defaults();
    logic [8:0] pat;
    pat = 9'b110011010;
    for (int i = 0; i < 9; i++) drive_bit(pat[i]);
    wait_idle();
  endtask

  // Code length zero with packet length zero: every bit is a one-word packet.
  // Then a 4-bit code with single-bit packets.
  task automatic test_short_packets();
    set_config(64'h0, 7'd0, 7'd0, 16'd0);
    drive_bit(1'b1);
    drive_bit(1'b0);
    wait_idle();
    set_config(64'hB, 7'd4, 7'd0, 16'd1);
    send_code(64'hB, 4, 0);
    drive_bit(1'b1);
    wait_idle();
  endtask

  // One wrong bit under a threshold of one, then thresholds of 64 and 127
  // (every comparison matches), the first with an over-long code length.
  task automatic test_threshold();
    set_config(64'hA5, 7'd8, 7'd1, 16'd3);
    send_code(64'hA5, 8, 1);
    drive_bit(1'b0);
    drive_bit(1'b1);
    wait_idle();
    set_config('1, 7'd127, 7'd64, 16'd2);
    drive_bit(1'b0);
    drive_bit(1'b1);
    wait_idle();
    set_config(64'h0, 7'd64, 7'd127, 16'd1);
    drive_bit(1'b1);
    drive_bit(1'b0);
    wait_idle();
  endtask

  // Long packet, with all registers rewritten while it is open: the
  // packet must run to its end and the new code apply only after it.
  task automatic test_long_packet();
    logic [63:0] code;
    gaps_on = 1'b0;
    set_config('1, 7'd1, 7'd0, 16'd600);
    drive_bit(1'b0);
    drive_bit(1'b1);
    send_noise(20);
    wait_idle();
    code = {$urandom, $urandom};
    set_config(code, 7'd64, 7'd0, 16'd3);
    send_noise(584);
    send_code(code, 64, 0);
    send_noise(4);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Random register settings, each followed by mostly well-formed code
  // sequences (some with too many wrong bits) and packet payload, plus noise.
  task automatic test_random_settings();
    logic [63:0] code;
    int          len;
    int          thr;
    int          pkt;
    int          start;
    int          phase_start;
    int          target;
    start = words_sent;
    while (words_sent - start < 1300) begin
      case ($urandom_range(0, 5))
        0: len = 1;
        1: len = 64;
        default: len = $urandom_range(2, 63);
      endcase
      thr  = $urandom_range(0, len / 8);
      pkt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      code = {$urandom, $urandom};
      set_config(code, 7'(len), 7'(thr), 16'(pkt));
      gaps_on     = ($urandom_range(0, 3) != 0);
      target      = $urandom_range(120, 250);
      phase_start = words_sent;
      while (words_sent - phase_start < target) begin
        if ($urandom_range(0, 9) < 7) begin
          send_code(code, len, $urandom_range(0, thr + 1));
          send_noise($urandom_range(0, pkt + 3));
        end else begin
          send_noise($urandom_range(1, 20));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_short_packets();
    test_threshold();
    test_long_packet();
    test_random_settings();
    wait_idle();
    $display("Run covered %0d input words and %0d checked output words over %0d settings,",
             words_sent, words_checked, settings_seen);
    $display("with %0d packets opened, one of them 600 bits long.", packets_seen);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
